### rtl/core/mstd_pkg.sv
`timescale 1ns / 1ps
package mstd_pkg;

   localparam int STACKS    = 3;
   localparam int LEVELS    = 4;
   localparam int DIM       = LEVELS + 1;
   localparam int CITY_W    = 6;
   localparam int DIST_BITS = 16;
   localparam int TOTAL_W   = 20;
   localparam int COUNT_W   = 4;
   localparam int HEIGHT_W  = 3;
   localparam int STACK_W   = 2;
   localparam int LEVEL_W   = 2;
   localparam int CSR_W     = 4;

   localparam int DIST_DEPTH = 4096;
   localparam int DIST_AW    = 12;
   localparam int ST_DEPTH   = DIM * DIM * DIM * STACKS;
   localparam int ST_AW      = 9;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [1:0] {
      ACT_DIST = 2'd0,
      ACT_SLOT = 2'd1,
      ACT_RUN  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_DEPOT  = 4'd0,
      CSR_PICKUP = 4'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMPACT,
      ST_CLEAR,
      ST_SEED,
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_NEXT,
      ST_RLX_RD,
      ST_RLX_WR,
      ST_FIN_LD,
      ST_FIN_CK,
      ST_DONE
   } state_type;

   typedef logic [CITY_W-1:0]                 city_type;
   typedef logic [LEVELS-1:0][CITY_W-1:0]     stack_cities_type;
   typedef logic [LEVELS-1:0]                 stack_full_type;
   typedef logic [STACKS-1:0][HEIGHT_W-1:0]   hvec_type;

   typedef struct packed {
      logic                reached;
      logic [TOTAL_W-1:0]  cost;
   } stage_entry_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  cand;
      logic                take;
   } alu_res_type;

   typedef struct packed {
      stack_cities_type     cities;
      stack_full_type       full;
      logic [HEIGHT_W-1:0]  count;
   } compact_res_type;

   function automatic logic [LEVEL_W-1:0] view_level(logic [HEIGHT_W-1:0] p, logic pickup);
      logic [HEIGHT_W-1:0] rev;
      rev = HEIGHT_W'(LEVELS - 1) - p;
      return pickup ? rev[LEVEL_W-1:0] : p[LEVEL_W-1:0];
   endfunction

   function automatic logic [ST_AW-1:0] st_addr(hvec_type h, logic [STACK_W-1:0] last);
      int unsigned acc;
      acc = 0;
      for (int r = STACKS - 1; r >= 0; r--) begin
         acc = acc * DIM + int'(h[r]);
      end
      return ST_AW'(acc * STACKS + int'(last));
   endfunction

endpackage

### rtl/core/mstd_ram.sv
`timescale 1ns / 1ps
module mstd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/mstd_compact.sv
`timescale 1ns / 1ps
module mstd_compact (
   input  mstd_pkg::stack_cities_type cities,
   input  mstd_pkg::stack_full_type   full,
   input  logic                       pickup,
   output mstd_pkg::compact_res_type  res
);

   mstd_pkg::stack_cities_type view;
   logic [mstd_pkg::HEIGHT_W-1:0] n;
   logic [mstd_pkg::LEVEL_W-1:0]  src;
   logic [mstd_pkg::LEVEL_W-1:0]  dst;

   always_comb begin
      n    = '0;
      view = '0;
      src  = '0;
      dst  = '0;
      for (int p = 0; p < mstd_pkg::LEVELS; p++) begin
         src = mstd_pkg::view_level(mstd_pkg::HEIGHT_W'(p), pickup);
         if (full[src]) begin
            view[n[mstd_pkg::LEVEL_W-1:0]] = cities[src];
            n = n + 1'b1;
         end
      end
      res.cities = cities;
      res.full   = '0;
      res.count  = n;
      for (int q = 0; q < mstd_pkg::LEVELS; q++) begin
         dst = mstd_pkg::view_level(mstd_pkg::HEIGHT_W'(q), pickup);
         if (mstd_pkg::HEIGHT_W'(q) < n) begin
            res.cities[dst] = view[q];
            res.full[dst]   = 1'b1;
         end
      end
   end

endmodule

### rtl/core/mstd_alu.sv
`timescale 1ns / 1ps
module mstd_alu (
   input  logic [mstd_pkg::TOTAL_W-1:0]   base,
   input  logic [mstd_pkg::DIST_BITS-1:0] leg_len,
   input  logic [mstd_pkg::TOTAL_W-1:0]   cur,
   input  logic                           cur_valid,
   output mstd_pkg::alu_res_type          res
);

   logic [mstd_pkg::TOTAL_W:0] sum;

   always_comb begin
      sum      = {1'b0, base} + {{(mstd_pkg::TOTAL_W + 1 - mstd_pkg::DIST_BITS){1'b0}}, leg_len};
      res.cand = sum[mstd_pkg::TOTAL_W] ? mstd_pkg::TOTAL_MAX : sum[mstd_pkg::TOTAL_W-1:0];
      res.take = !cur_valid || (res.cand < cur);
   end

endmodule

### rtl/core/multi_stack_tour_dp_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser: action; tdata: loads
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: total_distance, item_count
// csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
// Loads are accepted back to back while idle. A run compacts each stack, clears the
// stage store, visits each (heights, last) pair, scans the stacks from a reached pair,
// relaxing each candidate, and ends with a final check per last stack; its run time is
// set by the single port pair of the stage store and the one shared adder.
// Reset is synchronous; req is not ready during a run, and a finished result
// waits in the rsp register while loads continue.
module multi_stack_tour_dp_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // from_city, to_city, dist_value, stack_index,
                                   // level_index, slot_city, slot_empty, zero pad
   input  logic [1:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // total_distance, item_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [5:0]  csr_data
);

   mstd_pkg::state_type state_ff, state_in;

   mstd_pkg::stack_cities_type cities_ff [mstd_pkg::STACKS];
   mstd_pkg::stack_full_type   full_ff   [mstd_pkg::STACKS];

   logic [5:0] depot_ff;
   logic       pickup_ff;

   mstd_pkg::hvec_type occ_ff, occ_in;
   mstd_pkg::hvec_type h_ff, h_in;
   logic [mstd_pkg::STACK_W-1:0]  r_ff, r_in;
   logic [mstd_pkg::STACK_W-1:0]  last_ff, last_in;
   logic [mstd_pkg::ST_AW-1:0]    clr_ff, clr_in;
   logic [mstd_pkg::TOTAL_W-1:0]  base_ff, base_in;
   logic [mstd_pkg::TOTAL_W-1:0]  best_ff, best_in;
   logic [mstd_pkg::COUNT_W-1:0]  count_ff, count_in;
   mstd_pkg::city_type            prev_ff, prev_in;
   mstd_pkg::city_type            from_ff, from_in;
   mstd_pkg::city_type            to_ff, to_in;
   logic [mstd_pkg::ST_AW-1:0]    tgt_ff, tgt_in;
   logic                          seed_ff, seed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [23:0]                   rsp_data_ff, rsp_data_in;

   logic                          req_acc;
   logic [39:0]                   req_d;
   logic [mstd_pkg::STACK_W-1:0]  wr_stack;
   logic [mstd_pkg::LEVEL_W-1:0]  wr_level;

   logic                          dist_we;
   logic [mstd_pkg::DIST_AW-1:0]  dist_raddr;
   logic [mstd_pkg::DIST_BITS-1:0] dist_q;

   logic                          st_we;
   logic [mstd_pkg::ST_AW-1:0]    st_waddr;
   mstd_pkg::stage_entry_type     st_wdata;
   logic [mstd_pkg::ST_AW-1:0]    st_raddr;
   mstd_pkg::stage_entry_type     st_q;
   logic [$bits(mstd_pkg::stage_entry_type)-1:0] st_q_raw;

   mstd_pkg::compact_res_type     cres;
   logic                          cmp_we;

   logic [mstd_pkg::TOTAL_W-1:0]  alu_base;
   logic [mstd_pkg::TOTAL_W-1:0]  alu_cur;
   logic                          alu_cur_valid;
   mstd_pkg::alu_res_type         alu_res;

   mstd_pkg::hvec_type            htmp;
   logic [mstd_pkg::COUNT_W+1:0]  total;

   function automatic mstd_pkg::city_type view_city(
      mstd_pkg::stack_cities_type row, logic [mstd_pkg::HEIGHT_W-1:0] p, logic pickup);
      return row[mstd_pkg::view_level(p, pickup)];
   endfunction

   assign req_d      = req_tdata;
   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == mstd_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign wr_stack   = req_d[29:28];
   assign wr_level   = req_d[31:30];
   assign st_q       = mstd_pkg::stage_entry_type'(st_q_raw);

   assign dist_we = req_acc && (mstd_pkg::action_type'(req_tuser) == mstd_pkg::ACT_DIST);

   mstd_ram #(.WIDTH(mstd_pkg::DIST_BITS), .DEPTH(mstd_pkg::DIST_DEPTH)) u_dist (
      .clock (clock),
      .we    (dist_we),
      .waddr ({req_d[5:0], req_d[11:6]}),
      .wdata (req_d[27:12]),
      .raddr (dist_raddr),
      .rdata (dist_q)
   );

   mstd_ram #(.WIDTH($bits(mstd_pkg::stage_entry_type)), .DEPTH(mstd_pkg::ST_DEPTH)) u_stage (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_q_raw)
   );

   mstd_compact u_compact (
      .cities (cities_ff[r_ff]),
      .full   (full_ff[r_ff]),
      .pickup (pickup_ff),
      .res    (cres)
   );

   mstd_alu u_alu (
      .base      (alu_base),
      .leg_len   (dist_q),
      .cur       (alu_cur),
      .cur_valid (alu_cur_valid),
      .res       (alu_res)
   );

   always_comb begin
      if (state_ff == mstd_pkg::ST_FIN_CK) begin
         alu_base      = st_q.cost;
         alu_cur       = best_ff;
         alu_cur_valid = 1'b1;
      end else begin
         alu_base      = base_ff;
         alu_cur       = st_q.cost;
         alu_cur_valid = st_q.reached;
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      h_in         = h_ff;
      r_in         = r_ff;
      last_in      = last_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      tgt_in       = tgt_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      dist_raddr   = '0;
      st_raddr     = '0;
      st_we        = 1'b0;
      st_waddr     = tgt_ff;
      st_wdata     = '{reached: 1'b1, cost: alu_res.cand};
      cmp_we       = 1'b0;
      htmp         = h_ff;
      total        = '0;

      case (state_ff)
         mstd_pkg::ST_IDLE: begin
            r_in = '0;
            if (req_acc && mstd_pkg::action_type'(req_tuser) == mstd_pkg::ACT_RUN) begin
               state_in = mstd_pkg::ST_COMPACT;
            end
         end
         mstd_pkg::ST_COMPACT: begin
            cmp_we       = 1'b1;
            occ_in[r_ff] = cres.count;
            if (r_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               for (int r = 0; r < mstd_pkg::STACKS; r++) begin
                  total = total + (mstd_pkg::COUNT_W + 2)'(occ_in[r]);
               end
               count_in = total[mstd_pkg::COUNT_W-1:0];
               h_in     = occ_in;
               r_in     = '0;
               clr_in   = '0;
               best_in  = mstd_pkg::TOTAL_MAX;
               if (total == '0) begin
                  best_in  = '0;
                  state_in = mstd_pkg::ST_DONE;
               end else begin
                  state_in = mstd_pkg::ST_CLEAR;
               end
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         mstd_pkg::ST_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == mstd_pkg::ST_AW'(mstd_pkg::ST_DEPTH - 1)) begin
               state_in = mstd_pkg::ST_SEED;
            end
         end
         mstd_pkg::ST_SEED: begin
            if (occ_ff[r_ff] != '0) begin
               base_in    = '0;
               from_in    = depot_ff;
               htmp       = occ_ff;
               htmp[r_ff] = occ_ff[r_ff] - 1'b1;
               to_in      = view_city(cities_ff[r_ff], htmp[r_ff], pickup_ff);
               tgt_in     = mstd_pkg::st_addr(htmp, r_ff);
               seed_in    = 1'b1;
               state_in   = mstd_pkg::ST_RLX_RD;
            end else if (r_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               last_in  = '0;
               state_in = mstd_pkg::ST_LOAD;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         mstd_pkg::ST_LOAD: begin
            st_raddr = mstd_pkg::st_addr(h_ff, last_ff);
            state_in = mstd_pkg::ST_CHECK;
         end
         mstd_pkg::ST_CHECK: begin
            if (st_q.reached) begin
               base_in  = st_q.cost;
               prev_in  = view_city(cities_ff[last_ff], h_ff[last_ff], pickup_ff);
               r_in     = '0;
               state_in = mstd_pkg::ST_SCAN;
            end else begin
               state_in = mstd_pkg::ST_NEXT;
            end
         end
         mstd_pkg::ST_SCAN: begin
            if (h_ff[r_ff] != '0) begin
               htmp[r_ff] = h_ff[r_ff] - 1'b1;
               from_in    = prev_ff;
               to_in      = view_city(cities_ff[r_ff], htmp[r_ff], pickup_ff);
               tgt_in     = mstd_pkg::st_addr(htmp, r_ff);
               seed_in    = 1'b0;
               state_in   = mstd_pkg::ST_RLX_RD;
            end else if (r_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               state_in = mstd_pkg::ST_NEXT;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         mstd_pkg::ST_RLX_RD: begin
            dist_raddr = {from_ff, to_ff};
            st_raddr   = tgt_ff;
            state_in   = mstd_pkg::ST_RLX_WR;
         end
         mstd_pkg::ST_RLX_WR: begin
            st_we = alu_res.take;
            if (r_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               r_in = '0;
               if (seed_ff) begin
                  last_in  = '0;
                  state_in = mstd_pkg::ST_LOAD;
               end else begin
                  state_in = mstd_pkg::ST_NEXT;
               end
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = seed_ff ? mstd_pkg::ST_SEED : mstd_pkg::ST_SCAN;
            end
         end
         mstd_pkg::ST_NEXT: begin
            if (last_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               last_in = '0;
               if (mstd_pkg::st_addr(h_ff, '0) == mstd_pkg::ST_AW'(mstd_pkg::STACKS)) begin
                  state_in = mstd_pkg::ST_FIN_LD;
               end else begin
                  for (int r = 0; r < mstd_pkg::STACKS; r++) begin
                     if (htmp[r] != '0) begin
                        htmp[r] = htmp[r] - 1'b1;
                        break;
                     end else begin
                        htmp[r] = mstd_pkg::HEIGHT_W'(mstd_pkg::LEVELS);
                     end
                  end
                  h_in     = htmp;
                  state_in = mstd_pkg::ST_LOAD;
               end
            end else begin
               last_in  = last_ff + 1'b1;
               state_in = mstd_pkg::ST_LOAD;
            end
         end
         mstd_pkg::ST_FIN_LD: begin
            dist_raddr = {view_city(cities_ff[last_ff], '0, pickup_ff), depot_ff};
            st_raddr   = mstd_pkg::st_addr('0, last_ff);
            state_in   = mstd_pkg::ST_FIN_CK;
         end
         mstd_pkg::ST_FIN_CK: begin
            if (st_q.reached && alu_res.take) begin
               best_in = alu_res.cand;
            end
            if (last_ff == mstd_pkg::STACK_W'(mstd_pkg::STACKS - 1)) begin
               state_in = mstd_pkg::ST_DONE;
            end else begin
               last_in  = last_ff + 1'b1;
               state_in = mstd_pkg::ST_FIN_LD;
            end
         end
         mstd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ff, best_ff};
               state_in     = mstd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mstd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mstd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depot_ff     <= '0;
         pickup_ff    <= 1'b0;
         r_ff         <= '0;
         last_ff      <= '0;
         seed_ff      <= 1'b0;
         for (int s = 0; s < mstd_pkg::STACKS; s++) begin
            full_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         r_ff         <= r_in;
         last_ff      <= last_in;
         seed_ff      <= seed_in;
         if (csr_valid && csr_ready) begin
            if (mstd_pkg::csr_index_type'(csr_index) == mstd_pkg::CSR_DEPOT) begin
               depot_ff <= csr_data;
            end
            if (mstd_pkg::csr_index_type'(csr_index) == mstd_pkg::CSR_PICKUP) begin
               pickup_ff <= csr_data[0];
            end
         end
         if (req_acc && mstd_pkg::action_type'(req_tuser) == mstd_pkg::ACT_SLOT &&
             wr_stack < mstd_pkg::STACK_W'(mstd_pkg::STACKS)) begin
            full_ff[wr_stack][wr_level] <= !req_d[38];
         end
         if (cmp_we) begin
            full_ff[r_ff] <= cres.full;
         end
      end
   end

   always_ff @(posedge clock) begin
      occ_ff      <= occ_in;
      h_ff        <= h_in;
      clr_ff      <= clr_in;
      base_ff     <= base_in;
      best_ff     <= best_in;
      count_ff    <= count_in;
      prev_ff     <= prev_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      tgt_ff      <= tgt_in;
      rsp_data_ff <= rsp_data_in;
      if (req_acc && mstd_pkg::action_type'(req_tuser) == mstd_pkg::ACT_SLOT &&
          wr_stack < mstd_pkg::STACK_W'(mstd_pkg::STACKS)) begin
         cities_ff[wr_stack][wr_level] <= req_d[37:32];
      end
      if (cmp_we) begin
         cities_ff[r_ff] <= cres.cities;
      end
   end

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == mstd_pkg::ACT_RUN) |=> (state_ff == mstd_pkg::ST_COMPACT))
      else $error("run item did not start compaction");

   a_no_stage_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mstd_pkg::ST_IDLE) |-> !st_we)
      else $error("stage store written while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mstd_pkg::ST_DONE))
      else $error("result raised outside the done step");

endmodule
